// ----- hw/rtl/frq_pkg.sv -----
// Shared constants for the frame ring queue: operation and status codes,
// fixed field widths and stream bus widths.
// No dependencies.
package frq_pkg;

    localparam int CAP_W     = 6;
    localparam int FLEN_W    = 16;
    localparam int STAMP_W   = 64;
    localparam int LEN_OUT_W = 14;
    localparam int CNT_W     = 6;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 3;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DROP   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

endpackage

// ----- hw/rtl/frame_ring_queue_drop_oldest_top.sv -----
// Frame ring queue that drops the oldest frame when full.
// An input beat is taken into input registers; the EXEC phase computes the result and registers
// it to the output, waiting while m_tready low holds the previous beat. No new beat is taken
// until EXEC ends. Both memories are read in the accept cycle; EXEC read-modify-writes the indices.
// Reset: clears indices, offsets, count and push state, sets the capacity to
// QUEUE_SLOTS; memory contents are kept. Depends on frq_pkg and frq_store.
module frame_ring_queue_drop_oldest_top
    import frq_pkg::*;
#(
    parameter int QUEUE_SLOTS     = 32,
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CAP_W-1:0]      cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // data_in[7:0], frame_length[23:8], stamp_in[87:24]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // data_out[7:0], length_out[21:8], stamp_out[85:22], queue_count[91:86]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status[1:0], byte_valid[2]
    output logic [M_TUSER_W-1:0]  m_tuser,
    output logic                  m_tlast
);

    localparam int SLOT_W = $clog2(QUEUE_SLOTS);
    localparam int OFF_W  = $clog2(MAX_FRAME_BYTES);
    localparam int QS_W   = $clog2(QUEUE_SLOTS + 1);
    localparam int EFF_W  = (QS_W > CAP_W) ? QS_W : CAP_W;
    localparam logic [FLEN_W:0]    LEN_LIM  = (FLEN_W + 1)'(MAX_FRAME_BYTES);
    localparam logic [EFF_W-1:0]   SLOTS_E  = EFF_W'(QUEUE_SLOTS);
    localparam logic [CNT_W-1:0]   CNT_MAX  = {CNT_W{1'b1}};

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_EXEC = 1'b1;

    logic                 phase_reg, phase_next;
    logic [EFF_W-1:0]     cap_reg;
    logic [EFF_W-1:0]     eff;

    logic [1:0]           op_reg;
    logic [7:0]           din_reg;
    logic [FLEN_W-1:0]    flen_reg;
    logic [STAMP_W-1:0]   stamp_reg;
    logic                 last_reg;

    logic [SLOT_W-1:0]    ws_reg, ws_next, rs_reg, rs_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [OFF_W-1:0]     woff_reg, woff_next, roff_reg, roff_next;
    logic [OFF_W-1:0]     clen_reg, clen_next;
    logic                 act_reg, act_next, rej_reg, rej_next, drop_reg, drop_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic                 byte_we, meta_we;
    logic [SLOT_W+OFF_W-1:0] byte_waddr;
    logic [7:0]           byte_rdata;
    logic [OFF_W+STAMP_W-1:0] meta_rdata;
    logic [OFF_W-1:0]     meta_len;
    logic [STAMP_W-1:0]   meta_stamp;

    logic                 load;
    logic [OFF_W-1:0]     p_len, p_off;
    logic [CNT_W-1:0]     p_cnt;
    logic                 p_drop;
    logic [1:0]           o_status;
    logic [7:0]           o_data;
    logic                 o_valid, o_last;
    logic [OFF_W-1:0]     o_len;
    logic [STAMP_W-1:0]   o_stamp;

    function automatic logic [SLOT_W-1:0] nxt_slot(input logic [SLOT_W-1:0] s,
                                                   input logic [EFF_W-1:0] e);
        logic [EFF_W-1:0] n;
        n = EFF_W'(s) + EFF_W'(1);
        return (n >= e) ? '0 : n[SLOT_W-1:0];
    endfunction

    always_comb begin
        if (cap_reg == '0) begin
            eff = EFF_W'(1);
        end else if (cap_reg > SLOTS_E) begin
            eff = SLOTS_E;
        end else begin
            eff = cap_reg;
        end
    end

    assign s_tready   = aresetn && (phase_reg == PH_IDLE);
    assign meta_len   = meta_rdata[OFF_W-1:0];
    assign meta_stamp = meta_rdata[OFF_W+STAMP_W-1:OFF_W];

    always_comb begin
        phase_next = phase_reg;
        ws_next    = ws_reg;
        rs_next    = rs_reg;
        cnt_next   = cnt_reg;
        woff_next  = woff_reg;
        roff_next  = roff_reg;
        clen_next  = clen_reg;
        act_next   = act_reg;
        rej_next   = rej_reg;
        drop_next  = drop_reg;
        byte_we    = 1'b0;
        meta_we    = 1'b0;
        byte_waddr = {ws_reg, woff_reg};
        load       = 1'b0;
        p_len      = act_reg ? clen_reg : flen_reg[OFF_W-1:0];
        p_off      = act_reg ? woff_reg : '0;
        p_cnt      = cnt_reg;
        p_drop     = drop_reg;
        o_status   = ST_OK;
        o_data     = '0;
        o_valid    = 1'b0;
        o_last     = 1'b0;
        o_len      = '0;
        o_stamp    = '0;

        if (phase_reg == PH_IDLE) begin
            if (s_tvalid) begin
                phase_next = PH_EXEC;
            end
        end else if (!m_tvalid_reg || m_tready) begin
            load       = 1'b1;
            phase_next = PH_IDLE;
            case (op_reg)
                OP_PUSH: begin
                    if (rej_reg) begin
                        if (last_reg) begin
                            rej_next = 1'b0;
                        end
                        o_status = ST_REJECT;
                    end else if (!act_reg && ({1'b0, flen_reg} >= LEN_LIM)) begin
                        rej_next = !last_reg;
                        o_status = ST_REJECT;
                    end else begin
                        if (!act_reg) begin
                            if (EFF_W'(cnt_reg) >= eff) begin
                                rs_next   = nxt_slot(rs_reg, eff);
                                roff_next = '0;
                                p_drop    = 1'b1;
                                if (cnt_reg != '0) begin
                                    p_cnt = cnt_reg - CNT_W'(1);
                                end
                            end else begin
                                p_drop = 1'b0;
                            end
                            meta_we   = 1'b1;
                            clen_next = p_len;
                            act_next  = 1'b1;
                        end
                        if (p_off < p_len) begin
                            byte_we    = 1'b1;
                            byte_waddr = {ws_reg, p_off};
                            p_off      = p_off + OFF_W'(1);
                        end
                        if (last_reg || p_len == '0) begin
                            o_status = p_drop ? ST_DROP : ST_OK;
                            if (p_cnt != CNT_MAX) begin
                                p_cnt = p_cnt + CNT_W'(1);
                            end
                            ws_next  = nxt_slot(ws_reg, eff);
                            p_off    = '0;
                            act_next = 1'b0;
                            p_drop   = 1'b0;
                        end
                        woff_next = p_off;
                        cnt_next  = p_cnt;
                        drop_next = p_drop;
                    end
                end
                OP_POP: begin
                    if (cnt_reg == '0) begin
                        o_status = ST_EMPTY;
                    end else begin
                        o_len   = meta_len;
                        o_stamp = meta_stamp;
                        roff_next = roff_reg;
                        if (meta_len != '0 && roff_reg < meta_len) begin
                            o_data    = byte_rdata;
                            o_valid   = 1'b1;
                            roff_next = roff_reg + OFF_W'(1);
                        end
                        if (roff_next >= meta_len) begin
                            o_last    = 1'b1;
                            rs_next   = nxt_slot(rs_reg, eff);
                            cnt_next  = cnt_reg - CNT_W'(1);
                            roff_next = '0;
                        end
                    end
                end
                OP_CLEAR: begin
                    ws_next   = '0;
                    rs_next   = '0;
                    cnt_next  = '0;
                    woff_next = '0;
                    roff_next = '0;
                    act_next  = 1'b0;
                    rej_next  = 1'b0;
                    drop_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_TDATA_W - 8 - LEN_OUT_W - STAMP_W - CNT_W){1'b0}},
                             cnt_next, o_stamp, LEN_OUT_W'(o_len), o_data};
            m_tuser_next  = {o_valid, o_status};
            m_tlast_next  = o_last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            cap_reg      <= SLOTS_E;
            ws_reg       <= '0;
            rs_reg       <= '0;
            cnt_reg      <= '0;
            woff_reg     <= '0;
            roff_reg     <= '0;
            act_reg      <= 1'b0;
            rej_reg      <= 1'b0;
            drop_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            if (cfg_we) begin
                cap_reg <= EFF_W'(cfg_wdata);
            end
            ws_reg       <= ws_next;
            rs_reg       <= rs_next;
            cnt_reg      <= cnt_next;
            woff_reg     <= woff_next;
            roff_reg     <= roff_next;
            act_reg      <= act_next;
            rej_reg      <= rej_next;
            drop_reg     <= drop_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= s_tuser;
            din_reg   <= s_tdata[7:0];
            flen_reg  <= s_tdata[23:8];
            stamp_reg <= s_tdata[87:24];
            last_reg  <= s_tlast;
        end
        clen_reg    <= clen_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    frq_store #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .OFF_W       (OFF_W)
    ) u_store (
        .aclk       (aclk),
        .byte_we    (byte_we),
        .byte_waddr (byte_waddr),
        .byte_wdata (din_reg),
        .byte_raddr ({rs_reg, roff_reg}),
        .byte_rdata (byte_rdata),
        .meta_we    (meta_we),
        .meta_waddr (ws_reg),
        .meta_wdata ({stamp_reg, p_len}),
        .meta_raddr (rs_reg),
        .meta_rdata (meta_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- hw/rtl/frq_store.sv -----
// Frame byte memory and per-slot length/timestamp memory, one write and
// one registered read port each.
// Depends on frq_pkg.
module frq_store
    import frq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 32,
    parameter int OFF_W       = 14
) (
    input  logic                                  aclk,
    input  logic                                  byte_we,
    input  logic [$clog2(QUEUE_SLOTS)+OFF_W-1:0]  byte_waddr,
    input  logic [7:0]                            byte_wdata,
    input  logic [$clog2(QUEUE_SLOTS)+OFF_W-1:0]  byte_raddr,
    output logic [7:0]                            byte_rdata,
    input  logic                                  meta_we,
    input  logic [$clog2(QUEUE_SLOTS)-1:0]        meta_waddr,
    input  logic [OFF_W+STAMP_W-1:0]              meta_wdata,
    input  logic [$clog2(QUEUE_SLOTS)-1:0]        meta_raddr,
    output logic [OFF_W+STAMP_W-1:0]              meta_rdata
);

    localparam int BYTE_DEPTH = QUEUE_SLOTS * (2 ** OFF_W);

    logic [7:0]               byte_mem [0:BYTE_DEPTH-1];
    logic [OFF_W+STAMP_W-1:0] meta_mem [0:QUEUE_SLOTS-1];
    logic [7:0]               byte_rdata_reg;
    logic [OFF_W+STAMP_W-1:0] meta_rdata_reg;

    always_ff @(posedge aclk) begin
        if (byte_we) begin
            byte_mem[byte_waddr] <= byte_wdata;
        end
        byte_rdata_reg <= byte_mem[byte_raddr];
    end

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        meta_rdata_reg <= meta_mem[meta_raddr];
    end

    assign byte_rdata = byte_rdata_reg;
    assign meta_rdata = meta_rdata_reg;

endmodule

// ----- hw/rtl/frq_checker.sv -----
// Port-level checks for the frame ring queue, attached by bind.
// Depends on frq_pkg and frame_ring_queue_drop_oldest_top.
module frq_checker
    import frq_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    a_empty_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == ST_EMPTY |->
            m_tdata[91:86] == '0 && !m_tuser[2] && !m_tlast && m_tdata[85:0] == '0)
        else $error("empty status with nonzero payload");

    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == ST_OK)
        else $error("byte beat with non-ok status");

    a_drop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == ST_DROP |-> m_tdata[91:86] != '0 && !m_tlast)
        else $error("drop commit left an empty queue");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled beat changed");

endmodule

bind frame_ring_queue_drop_oldest_top frq_checker u_frq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
